FILE: hdl/pidpi_pkg.sv
// ----------------------------------------------------------------------------
// pidpi_pkg: shared types, codes and arithmetic helpers
// Configuration, controller state and result records, register and mode
// codes, and the saturating fixed-point helpers used by the control law.
// ----------------------------------------------------------------------------
package pidpi_pkg;

  // Controller modes
  localparam logic [1:0] MODE_PD  = 2'd0;
  localparam logic [1:0] MODE_PID = 2'd1;
  localparam logic [1:0] MODE_INC = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_KP       = 3'd1;
  localparam logic [2:0] REG_KI       = 3'd2;
  localparam logic [2:0] REG_KD       = 3'd3;
  localparam logic [2:0] REG_OUT_MAX  = 3'd4;
  localparam logic [2:0] REG_OUT_MIN  = 3'd5;
  localparam logic [2:0] REG_INT_LIM  = 3'd6;
  localparam logic [2:0] REG_DEADBAND = 3'd7;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        kp;
    logic [31:0]        ki;
    logic [31:0]        kd;
    logic signed [31:0] out_max;
    logic signed [31:0] out_min;
    logic [30:0]        integral_limit;
    logic [30:0]        deadband;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] latest_error;
    logic signed [31:0] prior_error;
    logic signed [31:0] integral_sum;
    logic signed [31:0] output_level;
  } state_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               limited;
    logic               held;
  } result_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > SAT_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return $signed(v[31:0]);
  endfunction

  // Saturating 32-bit add
  function automatic logic signed [31:0] add32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  // Unsigned fixed-point gain times signed value, floored, saturated
  function automatic logic signed [31:0] gmul(input logic [31:0] gain,
                                              input logic signed [31:0] x,
                                              input int unsigned frac);
    logic signed [65:0] p;
    p = $signed({34'd0, gain}) * $signed({{34{x[31]}}, x});
    return sat32(p >>> frac);
  endfunction

endpackage

FILE: hdl/pidpi_cfg.sv
// ----------------------------------------------------------------------------
// pidpi_cfg: configuration register file
// Holds mode, gains, output limits, integral limit and deadband; one write
// transaction updates one register. Reset values scale with FRAC_BITS.
// ----------------------------------------------------------------------------
module pidpi_cfg #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output pidpi_pkg::cfg_t  cfg
);

  localparam longint One     = longint'(1) << FRAC_BITS;
  localparam longint KpRaw   = 20 * One;
  localparam longint KdRaw   = 10 * One;
  localparam longint MaxRaw  = 10 * One;
  localparam longint MinRaw  = -150 * One;
  localparam longint LimRaw  = 100 * One;
  localparam longint KpSat   = (KpRaw > 64'sd4294967295) ? 64'sd4294967295 : KpRaw;
  localparam longint KdSat   = (KdRaw > 64'sd4294967295) ? 64'sd4294967295 : KdRaw;
  localparam longint MaxSat  = (MaxRaw > 64'sd2147483647) ? 64'sd2147483647 : MaxRaw;
  localparam longint MinSat  = (MinRaw < -64'sd2147483648) ? -64'sd2147483648 : MinRaw;
  localparam longint LimSat  = (LimRaw > 64'sd2147483647) ? 64'sd2147483647 : LimRaw;
  localparam longint KiRaw   = (One + 5) / 10;

  localparam logic [31:0]        KP_RST  = 32'(KpSat);
  localparam logic [31:0]        KI_RST  = 32'(KiRaw);
  localparam logic [31:0]        KD_RST  = 32'(KdSat);
  localparam logic signed [31:0] MAX_RST = 32'(MaxSat);
  localparam logic signed [31:0] MIN_RST = 32'(MinSat);
  localparam logic [30:0]        LIM_RST = 31'(LimSat);
  localparam logic [30:0]        DB_RST  = 31'(One);

  assign cfg_ready = 1'b1;

  // Load reset values, then take one register per write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= pidpi_pkg::MODE_INC;
      cfg.kp             <= KP_RST;
      cfg.ki             <= KI_RST;
      cfg.kd             <= KD_RST;
      cfg.out_max        <= MAX_RST;
      cfg.out_min        <= MIN_RST;
      cfg.integral_limit <= LIM_RST;
      cfg.deadband       <= DB_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pidpi_pkg::REG_MODE:     cfg.mode           <= cfg_data[1:0];
        pidpi_pkg::REG_KP:       cfg.kp             <= cfg_data;
        pidpi_pkg::REG_KI:       cfg.ki             <= cfg_data;
        pidpi_pkg::REG_KD:       cfg.kd             <= cfg_data;
        pidpi_pkg::REG_OUT_MAX:  cfg.out_max        <= $signed(cfg_data);
        pidpi_pkg::REG_OUT_MIN:  cfg.out_min        <= $signed(cfg_data);
        pidpi_pkg::REG_INT_LIM:  cfg.integral_limit <= cfg_data[30:0];
        pidpi_pkg::REG_DEADBAND: cfg.deadband       <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/pidpi_law.sv
// ----------------------------------------------------------------------------
// pidpi_law: control law datapath
// Forms the error, runs the positional or incremental law with three gain
// multipliers shared between modes, clamps the output and yields the next
// controller state together with the result record.
// ----------------------------------------------------------------------------
module pidpi_law #(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [31:0]  measured,
  input  logic signed [31:0]  target,
  input  pidpi_pkg::cfg_t     cfg,
  input  pidpi_pkg::state_t   state,
  output pidpi_pkg::state_t   state_next,
  output pidpi_pkg::result_t  result
);

  localparam int unsigned Frac = FRAC_BITS;

  always_comb begin
    logic signed [31:0] err;
    logic signed [32:0] err_ext;
    logic signed [32:0] mag;
    logic               positional;
    logic               active;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [31:0] prod_p;
    logic signed [31:0] prod_i;
    logic signed [31:0] prod_d;
    logic signed [31:0] lim;
    logic signed [31:0] isum;
    logic signed [31:0] raw;
    logic signed [31:0] val;

    err     = pidpi_pkg::sat32(66'(target) - 66'(measured));
    err_ext = 33'(err);
    mag     = err[31] ? -err_ext : err_ext;

    positional = (cfg.mode == pidpi_pkg::MODE_PD) || (cfg.mode == pidpi_pkg::MODE_PID);
    active     = !positional || (mag > $signed({2'b00, cfg.deadband}));

    // First and second differences of the error
    d1 = pidpi_pkg::sat32(66'(err) - 66'(state.latest_error));
    d2 = pidpi_pkg::sat32(66'(err) - (66'(state.latest_error) <<< 1)
                          + 66'(state.prior_error));

    // Share the three gain products between modes
    prod_p = pidpi_pkg::gmul(cfg.kp, positional ? err : d1, Frac);
    prod_i = pidpi_pkg::gmul(cfg.ki, err, Frac);
    prod_d = pidpi_pkg::gmul(cfg.kd, positional ? d1 : d2, Frac);

    // Clamp the running integral symmetrically
    lim  = $signed({1'b0, cfg.integral_limit});
    isum = pidpi_pkg::add32(state.integral_sum, prod_i);
    if (isum > lim) begin
      isum = lim;
    end
    if (isum < -lim) begin
      isum = -lim;
    end

    if (positional) begin
      raw = pidpi_pkg::add32(prod_p, prod_d);
      if (cfg.mode == pidpi_pkg::MODE_PID) begin
        raw = pidpi_pkg::add32(raw, isum);
      end
    end else begin
      raw = pidpi_pkg::add32(pidpi_pkg::add32(prod_p, prod_i), prod_d);
      raw = pidpi_pkg::add32(state.output_level, raw);
    end

    // Apply upper limit first, then lower
    val = raw;
    if (val > cfg.out_max) begin
      val = cfg.out_max;
    end
    if (val < cfg.out_min) begin
      val = cfg.out_min;
    end

    // Update state; a deadband hold leaves it untouched
    state_next = state;
    if (active) begin
      state_next.latest_error = err;
      state_next.output_level = val;
      if (!positional) begin
        state_next.prior_error = state.latest_error;
      end
      if (cfg.mode == pidpi_pkg::MODE_PID) begin
        state_next.integral_sum = isum;
      end
    end

    result.drive   = state_next.output_level;
    result.limited = active && (val != raw);
    result.held    = !active;
  end

endmodule

FILE: hdl/pid_position_incremental_top.sv
// ----------------------------------------------------------------------------
// pid_position_incremental_top: fixed-point PID controller, three modes
// Input register, single-pass control law, output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries measured and target, signed
//   Q.FRAC_BITS. Output channel (out_valid/out_ready) carries drive, limited
//   and held, one result per input transaction, in order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   one register per transaction; cfg_ready is always high. Write only while
//   no item is in flight.
//   Items pass the input register, then the output register. While out_ready
//   is high, throughput is one item per cycle. The controller state (errors,
//   integral, output level) is read and rewritten in the same single stage,
//   through the three gain multipliers, so that stage sets the clock.
//   Reset (rst, synchronous) loads the default configuration, zeroes the
//   controller state and empties both registers.
//   When the receiver stalls, the result waits in the output register, the
//   next item waits in the input register, and in_ready then drops.
// ----------------------------------------------------------------------------
module pid_position_incremental_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] measured,
  input  logic signed [31:0] target,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive,
  output logic               limited,
  output logic               held,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  pidpi_pkg::cfg_t    cfg;
  pidpi_pkg::state_t  state;
  pidpi_pkg::state_t  state_next;
  pidpi_pkg::result_t result;

  logic               stage_valid;
  logic signed [31:0] stage_measured;
  logic signed [31:0] stage_target;
  logic               fire;

  pidpi_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidpi_law #(
    .FRAC_BITS (FRAC_BITS)
  ) u_law (
    .measured   (stage_measured),
    .target     (stage_target),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // Advance the stage when the output register is free or being drained
  assign fire     = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || fire;

  // Capture input transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_measured <= measured;
      stage_target   <= target;
    end
  end

  // Commit controller state with each finished item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      drive   <= result.drive;
      limited <= result.limited;
      held    <= result.held;
    end
  end

endmodule

FILE: tb/tb_pid_position_incremental_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_position_incremental_top: self-checking bench for the PID controller
// Streams measured/target samples through the block in several register
// settings (all three control laws, the spare mode code, crossed and extreme
// limits, zero and full-scale gains). A cycle-accurate software copy of the
// controller predicts drive, limited and held for every accepted sample, and
// the monitor checks each result in order. Both sides idle at random, and the
// receiver holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module tb_pid_position_incremental_top;

  localparam int FRAC = 16;
  localparam longint Q_ONE = longint'(1) << FRAC;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  // Mode code left unused by the control law; behaves as incremental
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic signed [31:0] measured;
    logic signed [31:0] target;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] measured = '0;
  logic signed [31:0] target = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] drive;
  logic               limited;
  logic               held;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // Controller copy used for prediction
  pidpi_pkg::cfg_t   ctrl_cfg;
  pidpi_pkg::state_t ctrl_state;

  sample_t pending_samples[$];
  pidpi_pkg::result_t drive_expect[$];
  sample_t next_sample;
  logic [31:0] reg_plan [8];

  int items_sent = 0;
  int results_seen = 0;
  int errors = 0;
  int cycle = 0;
  int hold_left = 0;
  int holds_done = 0;
  longint sp_level = 0;
  int run_left = 0;
  logic calm;

  pid_position_incremental_top #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .measured(measured),
    .target(target),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive(drive),
    .limited(limited),
    .held(held),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Free-running cycle count; idling is off for a fifth of every window
  always @(posedge clk) begin
    cycle <= cycle + 1;
  end
  assign calm = (cycle % 2500) < 500;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the controller
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] clip32(input longint v);
    if (v > longint'(WORD_MAX)) begin
      return WORD_MAX;
    end
    if (v < longint'(WORD_MIN)) begin
      return WORD_MIN;
    end
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] sum32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return clip32(longint'(a) + longint'(b));
  endfunction

  // Unsigned gain times signed value, floored back to Q.FRAC, saturated
  function automatic logic signed [31:0] scale_gain(input logic [31:0] gain,
                                                    input logic signed [31:0] x);
    longint g;
    longint p;
    g = longint'(gain);
    p = g * longint'(x);
    return clip32(p >>> FRAC);
  endfunction

  function automatic logic signed [31:0] clamp_out(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] r;
    hi = ctrl_cfg.out_max;
    lo = ctrl_cfg.out_min;
    r = v;
    // Upper bound first, so the lower one wins when the limits cross
    if (r > hi) begin
      r = hi;
    end
    if (r < lo) begin
      r = lo;
    end
    return r;
  endfunction

  // Run one control step on the copy and return the result it produces
  function automatic pidpi_pkg::result_t predict_drive(input logic signed [31:0] meas,
                                                       input logic signed [31:0] tgt);
    pidpi_pkg::result_t r;
    logic signed [31:0] err;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [31:0] acc;
    logic signed [31:0] isum;
    logic signed [31:0] lim;
    logic signed [31:0] lvl;
    longint mag;
    r = '0;
    err = clip32(longint'(tgt) - longint'(meas));
    if (ctrl_cfg.mode == pidpi_pkg::MODE_PD || ctrl_cfg.mode == pidpi_pkg::MODE_PID) begin
      mag = (err < 0) ? -longint'(err) : longint'(err);
      if (mag > longint'(ctrl_cfg.deadband)) begin
        d1 = clip32(longint'(err) - longint'(ctrl_state.latest_error));
        acc = sum32(scale_gain(ctrl_cfg.kp, err), scale_gain(ctrl_cfg.kd, d1));
        if (ctrl_cfg.mode == pidpi_pkg::MODE_PID) begin
          lim = {1'b0, ctrl_cfg.integral_limit};
          isum = sum32(ctrl_state.integral_sum, scale_gain(ctrl_cfg.ki, err));
          if (isum > lim) begin
            isum = lim;
          end
          if (isum < -lim) begin
            isum = -lim;
          end
          ctrl_state.integral_sum = isum;
          acc = sum32(acc, isum);
        end
        lvl = clamp_out(acc);
        r.limited = (lvl != acc);
        ctrl_state.latest_error = err;
        ctrl_state.output_level = lvl;
      end else begin
        // Inside the deadband: keep the level and the old error
        r.held = 1'b1;
      end
    end else begin
      d1 = clip32(longint'(err) - longint'(ctrl_state.latest_error));
      d2 = clip32(longint'(err) - 2 * longint'(ctrl_state.latest_error)
                  + longint'(ctrl_state.prior_error));
      acc = sum32(sum32(scale_gain(ctrl_cfg.kp, d1), scale_gain(ctrl_cfg.ki, err)),
                  scale_gain(ctrl_cfg.kd, d2));
      acc = sum32(ctrl_state.output_level, acc);
      lvl = clamp_out(acc);
      r.limited = (lvl != acc);
      ctrl_state.prior_error = ctrl_state.latest_error;
      ctrl_state.latest_error = err;
      ctrl_state.output_level = lvl;
    end
    r.drive = ctrl_state.output_level;
    return r;
  endfunction

  task automatic reset_model();
    ctrl_cfg.mode = pidpi_pkg::MODE_INC;
    ctrl_cfg.kp = 32'(20 * Q_ONE);
    ctrl_cfg.ki = 32'((Q_ONE + 5) / 10);
    ctrl_cfg.kd = 32'(10 * Q_ONE);
    ctrl_cfg.out_max = 32'(10 * Q_ONE);
    ctrl_cfg.out_min = 32'(-150 * Q_ONE);
    ctrl_cfg.integral_limit = 31'(100 * Q_ONE);
    ctrl_cfg.deadband = 31'(Q_ONE);
    ctrl_state = '0;
  endtask

  task automatic update_model_reg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      pidpi_pkg::REG_MODE:     ctrl_cfg.mode = data[1:0];
      pidpi_pkg::REG_KP:       ctrl_cfg.kp = data;
      pidpi_pkg::REG_KI:       ctrl_cfg.ki = data;
      pidpi_pkg::REG_KD:       ctrl_cfg.kd = data;
      pidpi_pkg::REG_OUT_MAX:  ctrl_cfg.out_max = data;
      pidpi_pkg::REG_OUT_MIN:  ctrl_cfg.out_min = data;
      pidpi_pkg::REG_INT_LIM:  ctrl_cfg.integral_limit = data[30:0];
      pidpi_pkg::REG_DEADBAND: ctrl_cfg.deadband = data[30:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Write every register from reg_plan in index order
  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_index <= 3'(i);
      cfg_data <= reg_plan[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      update_model_reg(3'(i), reg_plan[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait until every sent sample has its result, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk); while (results_seen != items_sent);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_sample(input logic signed [31:0] m, input logic signed [31:0] t);
    pending_samples.push_back('{m, t});
    items_sent++;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(4 << FRAC);
    endcase
  endfunction

  task automatic plan_random_regs();
    logic [1:0] m;
    case ($urandom_range(9))
      0, 1, 2: m = pidpi_pkg::MODE_PD;
      3, 4, 5: m = pidpi_pkg::MODE_PID;
      9:       m = MODE_SPARE;
      default: m = pidpi_pkg::MODE_INC;
    endcase
    // Upper bits of the mode word are don't-care; fill them with noise
    reg_plan[pidpi_pkg::REG_MODE] = ($urandom() & 32'hFFFF_FFFC) | 32'(m);
    reg_plan[pidpi_pkg::REG_KP] = pick_gain();
    reg_plan[pidpi_pkg::REG_KI] = pick_gain();
    reg_plan[pidpi_pkg::REG_KD] = pick_gain();
    case ($urandom_range(9))
      0:       reg_plan[pidpi_pkg::REG_OUT_MAX] = WORD_MAX;
      1:       reg_plan[pidpi_pkg::REG_OUT_MAX] = $urandom();
      default: reg_plan[pidpi_pkg::REG_OUT_MAX] = $urandom_range(200 << FRAC, 1 << FRAC);
    endcase
    case ($urandom_range(9))
      0:       reg_plan[pidpi_pkg::REG_OUT_MIN] = WORD_MIN;
      1:       reg_plan[pidpi_pkg::REG_OUT_MIN] = $urandom();
      default: reg_plan[pidpi_pkg::REG_OUT_MIN] =
                 32'(-longint'($urandom_range(200 << FRAC, 1 << FRAC)));
    endcase
    case ($urandom_range(9))
      0:       reg_plan[pidpi_pkg::REG_INT_LIM] = '0;
      1:       reg_plan[pidpi_pkg::REG_INT_LIM] = 32'hFFFF_FFFF;
      default: reg_plan[pidpi_pkg::REG_INT_LIM] = $urandom_range(100 << FRAC);
    endcase
    case ($urandom_range(19))
      0:       reg_plan[pidpi_pkg::REG_DEADBAND] = '0;
      1:       reg_plan[pidpi_pkg::REG_DEADBAND] = $urandom();
      default: reg_plan[pidpi_pkg::REG_DEADBAND] = $urandom_range(2 << FRAC);
    endcase
  endtask

  // Mostly set-point tracking runs with the error near the deadband,
  // then mid-range noise and full-scale words
  task automatic push_random(input int n);
    int pick;
    longint span;
    longint off;
    longint m1;
    longint m2;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        if (run_left == 0) begin
          sp_level = longint'($urandom_range(100 << FRAC)) - (50 << FRAC);
          run_left = $urandom_range(40, 8);
        end
        run_left--;
        span = (ctrl_cfg.deadband < (1 << 22)) ? 2 * longint'(ctrl_cfg.deadband) + 2
                                                : longint'(1 << 22);
        off = longint'($urandom_range(32'(2 * span))) - span;
        queue_sample(32'(sp_level + off), 32'(sp_level));
      end else if (pick < 85) begin
        m1 = longint'($urandom_range(1 << 25)) - (1 << 24);
        m2 = longint'($urandom_range(1 << 25)) - (1 << 24);
        queue_sample(32'(m1), 32'(m2));
      end else begin
        queue_sample($urandom(), $urandom());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending samples, predict on each input transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        drive_expect.push_back(predict_drive(measured, target));
      end
      if (in_valid && !in_ready) begin
        // hold the offered sample until it is taken
      end else if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
        next_sample = pending_samples.pop_front();
        measured <= next_sample.measured;
        target <= next_sample.target;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-offs so the block fills and stalls its input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && results_seen >= 300) ||
                 (holds_done == 1 && results_seen >= 900)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each output transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pidpi_pkg::result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (drive_expect.size() == 0) begin
          $display("%0t: result with nothing expected: drive %0d limited %0b held %0b",
                   $time, drive, limited, held);
          errors++;
        end else begin
          want = drive_expect.pop_front();
          if (drive !== want.drive) begin
            $display("%0t: drive mismatch: expected %0d, actual %0d",
                     $time, want.drive, drive);
            errors++;
          end
          if (limited !== want.limited) begin
            $display("%0t: limited mismatch: expected %0b, actual %0b",
                     $time, want.limited, limited);
            errors++;
          end
          if (held !== want.held) begin
            $display("%0t: held mismatch: expected %0b, actual %0b",
                     $time, want.held, held);
            errors++;
          end
        end
      end
      out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 15);
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, incremental law: zero, unit steps, saturating errors
    queue_sample(32'sd0, 32'sd0);
    queue_sample(32'sd0, 32'(Q_ONE));
    queue_sample(32'(Q_ONE), 32'sd0);
    queue_sample(WORD_MIN, WORD_MAX);
    queue_sample(WORD_MAX, WORD_MIN);
    queue_sample(-32'sd1, -32'sd1);
    wait_idle();

    // Positional PD: deadband edges on both sides, full-range limits
    reg_plan[pidpi_pkg::REG_MODE] = pidpi_pkg::MODE_PD;
    reg_plan[pidpi_pkg::REG_KP] = 32'(Q_ONE);
    reg_plan[pidpi_pkg::REG_KI] = '0;
    reg_plan[pidpi_pkg::REG_KD] = 32'(Q_ONE / 2);
    reg_plan[pidpi_pkg::REG_OUT_MAX] = WORD_MAX;
    reg_plan[pidpi_pkg::REG_OUT_MIN] = WORD_MIN;
    reg_plan[pidpi_pkg::REG_INT_LIM] = 32'hFFFF_FFFF;
    reg_plan[pidpi_pkg::REG_DEADBAND] = 32'(Q_ONE);
    program_regs();
    queue_sample(32'sd0, 32'(Q_ONE));
    queue_sample(32'sd0, 32'(Q_ONE + 1));
    queue_sample(32'(Q_ONE), 32'sd0);
    queue_sample(32'(Q_ONE + 1), 32'sd0);
    queue_sample(32'sd5, 32'sd5);
    queue_sample(WORD_MIN, WORD_MAX);
    wait_idle();

    // Positional PID: integral runs into its clamp both ways, zero deadband
    reg_plan[pidpi_pkg::REG_MODE] = pidpi_pkg::MODE_PID;
    reg_plan[pidpi_pkg::REG_KP] = '0;
    reg_plan[pidpi_pkg::REG_KI] = 32'(Q_ONE / 2);
    reg_plan[pidpi_pkg::REG_KD] = '0;
    reg_plan[pidpi_pkg::REG_OUT_MAX] = 32'(100 * Q_ONE);
    reg_plan[pidpi_pkg::REG_OUT_MIN] = 32'(-100 * Q_ONE);
    reg_plan[pidpi_pkg::REG_INT_LIM] = 32'd100000;
    reg_plan[pidpi_pkg::REG_DEADBAND] = '0;
    program_regs();
    queue_sample(32'sd0, 32'sd200000);
    queue_sample(32'sd0, 32'sd200000);
    queue_sample(32'sd0, 32'sd200000);
    queue_sample(32'sd0, 32'sd0);
    queue_sample(32'sd200000, 32'sd0);
    queue_sample(32'sd200000, 32'sd0);
    queue_sample(WORD_MAX, WORD_MIN);
    wait_idle();

    // Spare mode code, full-scale gains, crossed output limits
    reg_plan[pidpi_pkg::REG_MODE] = MODE_SPARE;
    reg_plan[pidpi_pkg::REG_KP] = 32'hFFFF_FFFF;
    reg_plan[pidpi_pkg::REG_KI] = 32'hFFFF_FFFF;
    reg_plan[pidpi_pkg::REG_KD] = 32'hFFFF_FFFF;
    reg_plan[pidpi_pkg::REG_OUT_MAX] = 32'(-Q_ONE);
    reg_plan[pidpi_pkg::REG_OUT_MIN] = 32'(Q_ONE);
    reg_plan[pidpi_pkg::REG_INT_LIM] = '0;
    reg_plan[pidpi_pkg::REG_DEADBAND] = 32'h7FFF_FFFF;
    program_regs();
    queue_sample(32'sd0, 32'(Q_ONE));
    queue_sample(32'(Q_ONE), 32'sd0);
    queue_sample(WORD_MIN, WORD_MAX);
    wait_idle();

    // Random settings, each with a batch of random samples
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      plan_random_regs();
      program_regs();
      push_random(PHASE_ITEMS);
      wait_idle();
    end

    if (drive_expect.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, drive_expect.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
